[design/tdrp_pkg.sv]
// Shared types, register codes and fixed-point constants of the two-DOF rate PID.
package tdrp_pkg;

  // Field and register widths
  localparam int AXIS_W    = 2;
  localparam int FIELD_W   = 32;
  localparam int LANE_W    = 16;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;
  localparam int GAIN_AXES = 3;
  localparam int AXIS_SLOTS = 2 ** AXIS_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KP       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KI_DT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KD_DT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RELAX    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDUP   = 3'd6;

  // Axis codes
  localparam logic [AXIS_W-1:0] AX_ROLL  = 2'd0;
  localparam logic [AXIS_W-1:0] AX_PITCH = 2'd1;
  localparam logic [AXIS_W-1:0] AX_YAW   = 2'd2;
  localparam logic [AXIS_W-1:0] AX_BAD   = 2'd3;

  // Fixed-point constants
  localparam logic [15:0] MIX_ONE    = 16'd16384;  // 1.0 in Q2.14
  localparam logic [15:0] RELAX_ONE  = 16'd256;    // 1.0 in Q8.8
  localparam logic [16:0] UNITY_Q16  = 17'd65536;  // 1.0 in Q0.16
  localparam int          STEP_SHIFT = 12;         // Q12.4 to Q16.16

  // Register reset values
  localparam logic [15:0] WEIGHT_RST = 16'd30958;
  localparam logic [15:0] RELAX_RST  = 16'd256;
  localparam logic [15:0] WINDUP_RST = 16'd512;

  // Pick one axis's 16-bit gain out of a packed register
  function automatic logic [LANE_W-1:0] get_lane(input logic [CFG_W-1:0] packed_val,
                                                 input logic [AXIS_W-1:0] ax);
    logic [LANE_W-1:0] r;
    case (ax)
      AX_ROLL:  r = packed_val[15:0];
      AX_PITCH: r = packed_val[31:16];
      default:  r = packed_val[47:32];
    endcase
    return r;
  endfunction

endpackage

[design/tdrp_in_if.sv]
// Input channel: one axis sample per beat.
interface tdrp_in_if import tdrp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [AXIS_W-1:0]         axis;
  logic signed [FIELD_W-1:0] setpoint_rate;
  logic signed [FIELD_W-1:0] gyro_rate;
  logic [15:0]               throttle_attenuation;
  logic [15:0]               motor_mix_range;
  logic [15:0]               stick_deflection;
  logic [15:0]               iterm_boost;
  logic                      stabilise_on;
  logic                      clear_integral;

  modport source (output valid, axis, setpoint_rate, gyro_rate, throttle_attenuation,
                  motor_mix_range, stick_deflection, iterm_boost, stabilise_on,
                  clear_integral, input ready);
  modport sink (input valid, axis, setpoint_rate, gyro_rate, throttle_attenuation,
                motor_mix_range, stick_deflection, iterm_boost, stabilise_on,
                clear_integral, output ready);
endinterface

[design/tdrp_out_if.sv]
// Result channel: P, I and D terms of one axis per beat.
interface tdrp_out_if import tdrp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [AXIS_W-1:0]         out_axis;
  logic signed [FIELD_W-1:0] p_term;
  logic signed [FIELD_W-1:0] i_term;
  logic signed [FIELD_W-1:0] d_term;

  modport source (output valid, out_axis, p_term, i_term, d_term, input ready);
  modport sink (input valid, out_axis, p_term, i_term, d_term, output ready);
endinterface

[design/two_dof_rate_pid_axis.sv]
// Two-DOF rate PID top level: sequencer around one shared multiplier.
//
// One axis sample goes in, one beat with its P, I and D terms comes out. All
// products run through a single multiplier under a small state machine, one
// product per cycle. The longest path through the states is roll or pitch with
// the integrator running and stick relax on; yaw with a saturated mix skips the
// integral and derivative states, and an axis that is out of range goes
// straight to S_FIN. A new sample is taken in the cycle after its predecessor's
// result is loaded into the output register. The output register holds a
// finished result while the next sample is already being worked. Values are
// held signed with DATA_WIDTH bits and saturated after each add, subtract and
// multiply; products are rounded toward minus infinity. Configuration writes
// must land while the block is idle.
module two_dof_rate_pid_axis import tdrp_pkg::*; #(
  parameter int AXIS_COUNT = 3,
  parameter int DATA_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  tdrp_in_if.sink              in_ch,
  tdrp_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int DW = DATA_WIDTH;
  localparam int AW = DW + 1;        // multiplier A operand, signed
  localparam int PW = DW + 19;       // product and wide-sum width
  localparam int NA = (AXIS_COUNT < GAIN_AXES) ? AXIS_COUNT : GAIN_AXES;
  localparam logic [AXIS_W:0] NA_V = (AXIS_W + 1)'(NA);
  localparam logic signed [PW-1:0] SAT_HI  = {{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [PW-1:0] SAT_LO  = ~SAT_HI;
  localparam logic signed [PW-1:0] UNITY_P = PW'(UNITY_Q16);

  typedef enum logic [4:0] {
    S_IDLE, S_SLEW, S_ERR, S_P1, S_P2, S_P3,
    S_I0, S_I1, S_I2, S_I3, S_I4,
    S_DC, S_D0, S_D1, S_D2, S_DS, S_DW, S_DL, S_DK, S_DT, S_DE,
    S_FIN
  } state_t;

  // Saturate a wide value to DW bits
  function automatic logic signed [DW-1:0] sat_dw(input logic signed [PW-1:0] v);
    logic signed [DW-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[DW-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[DW-1:0];
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

  // Widen a DW value for sums
  function automatic logic signed [PW-1:0] ext(input logic signed [DW-1:0] v);
    return PW'(v);
  endfunction

  // Shift a product right and saturate
  function automatic logic signed [DW-1:0] shsat(input logic signed [PW-1:0] p,
                                                 input int sh);
    return sat_dw(p >>> sh);
  endfunction

  // Shift a nonnegative product right and cap at 1.0 in Q0.16
  function automatic logic [16:0] cap_one(input logic signed [PW-1:0] p, input int sh);
    logic signed [PW-1:0] t;
    logic [16:0]          r;
    t = p >>> sh;
    if (t > UNITY_P) begin
      r = UNITY_Q16;
    end else begin
      r = t[16:0];
    end
    return r;
  endfunction

  // Configuration registers
  logic [CFG_W-1:0] kp_r, ki_r, kd_r, max_step_r;
  logic [15:0]      weight_r, relax_r, windup_r;

  // Controller state
  logic signed [DW-1:0] prev_sp_r [AXIS_SLOTS];
  logic signed [DW-1:0] integ_r   [AXIS_SLOTS];
  logic signed [DW-1:0] last_d_r  [AXIS_SLOTS];
  logic signed [DW-1:0] pwe_r     [2];

  // Sequencer and work registers
  state_t               state_r;
  logic [AXIS_W-1:0]    ax_r;
  logic                 ax_ok_r;
  logic                 on_r;
  logic signed [DW-1:0] sp_r, gy_r, err_r, p_r, rd_r, delta_r;
  logic [15:0]          tpa_r, mix_r, stick_r, boost_r;
  logic [16:0]          dyn_r, c_r;
  logic signed [PW-1:0] prod_r;

  // Output register
  logic                 out_valid_r;
  logic [AXIS_W-1:0]    out_axis_r;
  logic signed [DW-1:0] out_p_r, out_i_r, out_d_r;

  logic signed [AW-1:0] mul_a;
  logic [16:0]          mul_b;
  logic signed [PW-1:0] prod_nxt;
  logic signed [DW-1:0] slew_sp;
  logic [LANE_W-1:0]    kp_lane, ki_lane, kd_lane, step_lane;
  logic                 in_fire, fin_go;

  assign kp_lane   = get_lane(kp_r, ax_r);
  assign ki_lane   = get_lane(ki_r, ax_r);
  assign kd_lane   = get_lane(kd_r, ax_r);
  assign step_lane = get_lane(max_step_r, ax_r);

  assign in_ch.ready     = (state_r == S_IDLE);
  assign in_fire         = in_ch.valid && in_ch.ready;
  assign fin_go          = !out_valid_r || out_ch.ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_axis = out_axis_r;
  assign out_ch.p_term   = FIELD_W'(out_p_r);
  assign out_ch.i_term   = FIELD_W'(out_i_r);
  assign out_ch.d_term   = FIELD_W'(out_d_r);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r       <= '0;
      ki_r       <= '0;
      kd_r       <= '0;
      max_step_r <= '0;
      weight_r   <= WEIGHT_RST;
      relax_r    <= RELAX_RST;
      windup_r   <= WINDUP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KP:       kp_r       <= cfg_data;
        CFG_KI_DT:    ki_r       <= cfg_data;
        CFG_KD_DT:    kd_r       <= cfg_data;
        CFG_MAX_STEP: max_step_r <= cfg_data;
        CFG_WEIGHT:   weight_r   <= cfg_data[15:0];
        CFG_RELAX:    relax_r    <= cfg_data[15:0];
        CFG_WINDUP:   windup_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Clamp the setpoint change to the axis step limit
  always_comb begin
    logic signed [PW-1:0] m_ext, prev_ext, vel, mag;
    m_ext    = PW'($signed({1'b0, step_lane, {STEP_SHIFT{1'b0}}}));
    prev_ext = ext(prev_sp_r[ax_r]);
    vel      = ext(sp_r) - prev_ext;
    mag      = (vel < 0) ? -vel : vel;
    slew_sp  = sp_r;
    if (mag > m_ext) begin
      slew_sp = (vel > 0) ? sat_dw(prev_ext + m_ext) : sat_dw(prev_ext - m_ext);
    end
  end

  // Select the shared multiplier's operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_P1: begin
        mul_a = AW'(err_r);
        mul_b = {1'b0, kp_lane};
      end
      S_P2: begin
        mul_a = AW'(shsat(prod_r, 8));
        mul_b = {1'b0, tpa_r};
      end
      S_I0: begin
        mul_a = AW'($signed({1'b0, 16'(MIX_ONE - mix_r)}));
        mul_b = {1'b0, windup_r};
      end
      S_I1: begin
        mul_a = AW'(err_r);
        mul_b = {1'b0, ki_lane};
      end
      S_I2: begin
        mul_a = AW'(shsat(prod_r, 16));
        mul_b = dyn_r;
      end
      S_I3: begin
        mul_a = AW'(shsat(prod_r, 16));
        mul_b = {1'b0, boost_r};
      end
      S_D0: begin
        mul_a = AW'($signed({1'b0, stick_r}));
        mul_b = {1'b0, relax_r};
      end
      S_D1: begin
        mul_a = AW'($signed({1'b0, weight_r}));
        mul_b = cap_one(prod_r, 7);
      end
      S_DS: begin
        mul_a = AW'(sp_r);
        mul_b = c_r;
      end
      S_DK: begin
        mul_a = AW'(delta_r);
        mul_b = {1'b0, kd_lane};
      end
      S_DT: begin
        mul_a = AW'(shsat(prod_r, 8));
        mul_b = {1'b0, tpa_r};
      end
      default: ;
    endcase
  end

  assign prod_nxt = mul_a * $signed({1'b0, mul_b});

  // Sequence one sample through the shared multiplier
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < AXIS_SLOTS; i++) begin
        prev_sp_r[i] <= '0;
        integ_r[i]   <= '0;
        last_d_r[i]  <= '0;
      end
      pwe_r[0] <= '0;
      pwe_r[1] <= '0;
    end else begin
      // Drop the result once taken, unless a new one is loaded in its place
      if (out_valid_r && out_ch.ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            ax_r    <= in_ch.axis;
            ax_ok_r <= ({1'b0, in_ch.axis} < NA_V);
            on_r    <= in_ch.stabilise_on;
            sp_r    <= sat_dw(PW'(in_ch.setpoint_rate));
            gy_r    <= sat_dw(PW'(in_ch.gyro_rate));
            tpa_r   <= in_ch.throttle_attenuation;
            mix_r   <= in_ch.motor_mix_range;
            stick_r <= in_ch.stick_deflection;
            boost_r <= in_ch.iterm_boost;
            if (in_ch.clear_integral) begin
              for (int i = 0; i < AXIS_SLOTS; i++) begin
                integ_r[i] <= '0;
              end
            end
            state_r <= ({1'b0, in_ch.axis} < NA_V) ? S_SLEW : S_FIN;
          end
        end
        S_SLEW: begin
          if (step_lane != '0) begin
            sp_r            <= slew_sp;
            prev_sp_r[ax_r] <= slew_sp;
          end
          state_r <= S_ERR;
        end
        S_ERR: begin
          err_r   <= sat_dw(ext(sp_r) - ext(gy_r));
          state_r <= S_P1;
        end
        S_P1: state_r <= S_P2;
        S_P2: state_r <= S_P3;
        S_P3: begin
          p_r <= shsat(prod_r, 15);
          if (mix_r < MIX_ONE) begin
            state_r <= S_I0;
          end else begin
            state_r <= (ax_r == AX_YAW) ? S_FIN : S_DC;
          end
        end
        S_I0: state_r <= S_I1;
        S_I1: begin
          dyn_r   <= cap_one(prod_r, 6);
          state_r <= S_I2;
        end
        S_I2: state_r <= S_I3;
        S_I3: state_r <= S_I4;
        S_I4: begin
          integ_r[ax_r] <= sat_dw(ext(integ_r[ax_r]) + ext(shsat(prod_r, 8)));
          state_r       <= (ax_r == AX_YAW) ? S_FIN : S_DC;
        end
        S_DC: begin
          // Scale the setpoint weight only when stick relax is above 1.0
          if (relax_r > RELAX_ONE) begin
            state_r <= S_D0;
          end else begin
            c_r     <= {1'b0, weight_r};
            state_r <= S_DS;
          end
        end
        S_D0: state_r <= S_D1;
        S_D1: state_r <= S_D2;
        S_D2: begin
          c_r     <= {1'b0, prod_r[31:16]};
          state_r <= S_DS;
        end
        S_DS: state_r <= S_DW;
        S_DW: begin
          rd_r    <= sat_dw(ext(shsat(prod_r, 16)) - ext(gy_r));
          state_r <= S_DL;
        end
        S_DL: begin
          delta_r       <= sat_dw(ext(rd_r) - ext(pwe_r[ax_r[0]]));
          pwe_r[ax_r[0]] <= rd_r;
          state_r       <= S_DK;
        end
        S_DK: state_r <= S_DT;
        S_DT: state_r <= S_DE;
        S_DE: begin
          last_d_r[ax_r] <= shsat(prod_r, 15);
          state_r        <= S_FIN;
        end
        S_FIN: begin
          // Load the result once the output register is free
          if (fin_go) begin
            out_valid_r <= 1'b1;
            out_axis_r  <= ax_r;
            out_p_r     <= (ax_ok_r && on_r) ? p_r : '0;
            out_i_r     <= (ax_ok_r && on_r) ? integ_r[ax_r] : '0;
            out_d_r     <= (ax_ok_r && on_r) ? last_d_r[ax_r] : '0;
            if (ax_ok_r && !on_r) begin
              integ_r[ax_r]  <= '0;
              last_d_r[ax_r] <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[design/tdrp_checker.sv]
// Port-level checks for the two-DOF rate PID and their binding to the top level.
module tdrp_checker import tdrp_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [AXIS_W-1:0]         out_axis,
  input logic signed [FIELD_W-1:0] p_term,
  input logic signed [FIELD_W-1:0] i_term,
  input logic signed [FIELD_W-1:0] d_term
);

  logic [1:0] pending_r;

  // Count samples taken but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 2'd0;
    end else begin
      case ({in_valid && in_ready, out_valid && out_ready})
        2'b10:   pending_r <= pending_r + 2'd1;
        2'b01:   pending_r <= pending_r - 2'd1;
        default: pending_r <= pending_r;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_axis) && $stable(p_term)
      && $stable(i_term) && $stable(d_term))
    else $error("result beat changed while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("sample taken while previous one still in work");

  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= 2'd2)
    else $error("more than two samples outstanding");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 2'd0)
    else $error("result beat without a sample behind it");

  a_bad_axis_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_axis == AX_BAD |-> p_term == '0 && i_term == '0 && d_term == '0)
    else $error("nonzero terms for an invalid axis");

endmodule

bind two_dof_rate_pid_axis tdrp_checker u_tdrp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_axis  (out_ch.out_axis),
  .p_term    (out_ch.p_term),
  .i_term    (out_ch.i_term),
  .d_term    (out_ch.d_term)
);

[verif/tb_top.sv]
// Self-checking testbench for the two-DOF rate PID: random and directed axis samples.
`timescale 1ns / 1ps

module tb_top;
  import tdrp_pkg::*;

  localparam int     N_AXES        = 3;
  localparam int     N_PHASES      = 8;
  localparam int     PHASE_SAMPLES = 130;
  localparam int     SETTLE_CYCLES = 30;
  localparam int     HOLD_CYCLES   = 400;
  localparam int     RUN_LIMIT_NS  = 2000000;
  localparam int     DEG           = 65536;          // 1 deg/s in Q16.16
  localparam int     Q_MAX         = 32'sh7FFF_FFFF;
  localparam int     Q_MIN         = 32'sh8000_0000;
  localparam longint WORD_MAX      = 64'sd2147483647;
  localparam longint WORD_MIN      = -64'sd2147483648;

  typedef struct packed {
    logic [AXIS_W-1:0]         axis;
    logic signed [FIELD_W-1:0] setpoint_rate;
    logic signed [FIELD_W-1:0] gyro_rate;
    logic [15:0]               throttle_attenuation;
    logic [15:0]               motor_mix_range;
    logic [15:0]               stick_deflection;
    logic [15:0]               iterm_boost;
    logic                      stabilise_on;
    logic                      clear_integral;
  } axis_sample_t;

  typedef struct packed {
    logic [AXIS_W-1:0]         out_axis;
    logic signed [FIELD_W-1:0] p_term;
    logic signed [FIELD_W-1:0] i_term;
    logic signed [FIELD_W-1:0] d_term;
  } pid_terms_t;

  typedef struct packed {
    logic [CFG_W-1:0] kp;
    logic [CFG_W-1:0] ki_dt;
    logic [CFG_W-1:0] kd_dt;
    logic [CFG_W-1:0] max_step;
    logic [15:0]      weight;
    logic [15:0]      relax;
    logic [15:0]      windup;
  } tuning_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  tdrp_in_if  in_ch();
  tdrp_out_if out_ch();

  two_dof_rate_pid_axis #(
    .AXIS_COUNT (N_AXES),
    .DATA_WIDTH (FIELD_W)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Controller mirror: register copy and per-axis state
  tuning_t active_tuning;
  longint  prev_setpoint [N_AXES];
  longint  integral_sum [N_AXES];
  longint  prev_weighted_err [2];
  longint  last_derivative [N_AXES];

  axis_sample_t pending_samples [$];
  pid_terms_t   expected_terms_q [$];
  int           queued_count   = 0;
  int           accepted_count = 0;
  int           mismatch_count = 0;
  int           walk_sp [AXIS_SLOTS];

  bit sample_taken  = 1'b0;
  bit send_idle_on  = 1'b0;
  bit recv_idle_on  = 1'b0;
  int send_gap      = 0;
  int recv_gap      = 0;
  int hold_off_left = 0;

  function automatic longint clamp_word(input longint x);
    if (x > WORD_MAX) return WORD_MAX;
    if (x < WORD_MIN) return WORD_MIN;
    return x;
  endfunction

  // Product shifted down with floor rounding, then saturated
  function automatic longint scale_clamp(input longint a, input longint b, input int sh);
    return clamp_word((a * b) >>> sh);
  endfunction

  function automatic longint gain_lane(input logic [CFG_W-1:0] word, input int ax);
    return longint'(word[16*ax +: 16]);
  endfunction

  // Advance the mirror by one sample and return the terms it must produce
  function automatic pid_terms_t predict_pid_terms(input axis_sample_t s);
    pid_terms_t r;
    int         ax;
    longint     sp, gy, tpa, lim, prev, vel, err, p, dyn, inc, c, f, wt_err, delta;
    longint     unity;
    ax    = int'(s.axis);
    sp    = longint'(s.setpoint_rate);
    gy    = longint'(s.gyro_rate);
    tpa   = longint'(s.throttle_attenuation);
    unity = longint'(UNITY_Q16);
    r.out_axis = s.axis;
    r.p_term   = '0;
    r.i_term   = '0;
    r.d_term   = '0;
    if (s.clear_integral) begin
      for (int k = 0; k < N_AXES; k++) integral_sum[k] = 0;
    end
    if (ax < N_AXES) begin
      // slew-limit the setpoint against the last limited value
      lim = gain_lane(active_tuning.max_step, ax) <<< STEP_SHIFT;
      if (lim != 0) begin
        prev = prev_setpoint[ax];
        vel  = sp - prev;
        if (vel > lim) sp = clamp_word(prev + lim);
        else if (vel < -lim) sp = clamp_word(prev - lim);
        prev_setpoint[ax] = sp;
      end
      err = clamp_word(sp - gy);
      p   = scale_clamp(scale_clamp(err, gain_lane(active_tuning.kp, ax), 8), tpa, 15);

      // integrate only while the mixer has headroom
      if (s.motor_mix_range < MIX_ONE) begin
        dyn = (longint'(MIX_ONE - s.motor_mix_range) * longint'(active_tuning.windup)) >>> 6;
        if (dyn > unity) dyn = unity;
        inc = scale_clamp(err, gain_lane(active_tuning.ki_dt, ax), 16);
        inc = scale_clamp(inc, dyn, 16);
        inc = scale_clamp(inc, longint'(s.iterm_boost), 8);
        integral_sum[ax] = clamp_word(integral_sum[ax] + inc);
      end

      // derivative on weighted setpoint, roll and pitch only
      if (s.axis != AX_YAW) begin
        c = longint'(active_tuning.weight);
        if (active_tuning.relax > RELAX_ONE) begin
          f = (longint'(s.stick_deflection) * longint'(active_tuning.relax)) >>> 7;
          if (f > unity) f = unity;
          c = (c * f) >>> 16;
        end
        wt_err = clamp_word(scale_clamp(sp, c, 16) - gy);
        delta  = clamp_word(wt_err - prev_weighted_err[ax]);
        prev_weighted_err[ax] = wt_err;
        last_derivative[ax] = scale_clamp(
            scale_clamp(delta, gain_lane(active_tuning.kd_dt, ax), 8), tpa, 15);
      end

      if (!s.stabilise_on) begin
        p = 0;
        integral_sum[ax]    = 0;
        last_derivative[ax] = 0;
      end
      r.p_term = FIELD_W'(p);
      r.i_term = FIELD_W'(integral_sum[ax]);
      r.d_term = FIELD_W'(last_derivative[ax]);
    end
    return r;
  endfunction

  function automatic axis_sample_t make_sample(input logic [AXIS_W-1:0] ax, input int sp,
                                               input int gy, input int tpa, input int mix,
                                               input int stick, input int boost,
                                               input bit on, input bit clr);
    axis_sample_t s;
    s.axis                 = ax;
    s.setpoint_rate        = sp;
    s.gyro_rate            = gy;
    s.throttle_attenuation = 16'(tpa);
    s.motor_mix_range      = 16'(mix);
    s.stick_deflection     = 16'(stick);
    s.iterm_boost          = 16'(boost);
    s.stabilise_on         = on;
    s.clear_integral       = clr;
    return s;
  endfunction

  // Mostly plausible flight samples; wild ones use the full field range
  function automatic axis_sample_t random_sample(input bit wild);
    axis_sample_t s;
    int           r, ax;
    r = $urandom_range(0, 99);
    if (r < 4) s.axis = AX_BAD;
    else if (r < 36) s.axis = AX_ROLL;
    else if (r < 68) s.axis = AX_PITCH;
    else s.axis = AX_YAW;
    ax = int'(s.axis);
    if (wild) begin
      s.setpoint_rate = $urandom;
      s.gyro_rate     = $urandom;
    end else begin
      if ($urandom_range(0, 1) == 0)
        walk_sp[ax] = walk_sp[ax] + int'($urandom_range(0, 1048576)) - 524288;
      else
        walk_sp[ax] = int'($urandom_range(0, 157286400)) - 78643200;
      s.setpoint_rate = walk_sp[ax];
      s.gyro_rate     = walk_sp[ax] + int'($urandom_range(0, 6553600)) - 3276800;
    end
    r = $urandom_range(0, 9);
    s.throttle_attenuation = (r == 0) ? 16'd0 : (r == 1) ? 16'd32768 :
                             16'($urandom_range(0, 32768));
    r = $urandom_range(0, 9);
    if (r < 7) s.motor_mix_range = 16'($urandom_range(0, 16383));
    else if (r == 7) s.motor_mix_range = MIX_ONE - 16'($urandom_range(0, 1));
    else s.motor_mix_range = 16'($urandom);
    s.stick_deflection = ($urandom_range(0, 9) == 0) ? 16'd32768 :
                         16'($urandom_range(0, 32768));
    s.iterm_boost      = ($urandom_range(0, 9) < 7) ? 16'd256 : 16'($urandom);
    s.stabilise_on     = ($urandom_range(0, 19) != 0);
    s.clear_integral   = ($urandom_range(0, 32) == 0);
    return s;
  endfunction

  function automatic logic [15:0] random_lane();
    return ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 16'h0400)) : 16'($urandom);
  endfunction

  function automatic logic [15:0] random_step_lane();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return 16'd0;
    if (r < 7) return 16'($urandom_range(1, 16'h0200));
    return 16'($urandom);
  endfunction

  function automatic tuning_t random_tuning();
    tuning_t t;
    int      r;
    t.kp       = {random_lane(), random_lane(), random_lane()};
    t.ki_dt    = {random_lane(), random_lane(), random_lane()};
    t.kd_dt    = {random_lane(), random_lane(), random_lane()};
    t.max_step = {random_step_lane(), random_step_lane(), random_step_lane()};
    t.weight   = 16'($urandom);
    r = $urandom_range(0, 3);
    if (r == 0) t.relax = RELAX_ONE;
    else if (r == 1) t.relax = RELAX_ONE + 16'd1;
    else if (r == 2) t.relax = 16'($urandom_range(0, 255));
    else t.relax = 16'($urandom_range(257, 65535));
    t.windup = 16'($urandom);
    return t;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic offer(input axis_sample_t s);
    pending_samples.push_back(s);
    queued_count++;
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  // Write every register; the block is idle, so the mirror can switch at once
  task automatic apply_settings(input tuning_t t);
    active_tuning = t;
    put_reg(CFG_KP, t.kp);
    put_reg(CFG_KI_DT, t.ki_dt);
    put_reg(CFG_KD_DT, t.kd_dt);
    put_reg(CFG_MAX_STEP, t.max_step);
    put_reg(CFG_WEIGHT, CFG_W'(t.weight));
    put_reg(CFG_RELAX, CFG_W'(t.relax));
    put_reg(CFG_WINDUP, CFG_W'(t.windup));
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Hold until every offered sample is taken and every result is back
  task automatic settle();
    do @(negedge clk);
    while (accepted_count != queued_count || expected_terms_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Take input beats into the mirror and check result beats
  always @(posedge clk) begin : monitor
    axis_sample_t got_in;
    pid_terms_t   want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        got_in.axis                 = in_ch.axis;
        got_in.setpoint_rate        = in_ch.setpoint_rate;
        got_in.gyro_rate            = in_ch.gyro_rate;
        got_in.throttle_attenuation = in_ch.throttle_attenuation;
        got_in.motor_mix_range      = in_ch.motor_mix_range;
        got_in.stick_deflection     = in_ch.stick_deflection;
        got_in.iterm_boost          = in_ch.iterm_boost;
        got_in.stabilise_on         = in_ch.stabilise_on;
        got_in.clear_integral       = in_ch.clear_integral;
        expected_terms_q.push_back(predict_pid_terms(got_in));
        accepted_count++;
        sample_taken = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_terms_q.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing pending, axis %0d",
                                    out_ch.out_axis));
        end else begin
          want = expected_terms_q.pop_front();
          if (out_ch.out_axis !== want.out_axis)
            report_mismatch($sformatf("out_axis %0d, want %0d", out_ch.out_axis,
                                      want.out_axis));
          if (out_ch.p_term !== want.p_term)
            report_mismatch($sformatf("axis %0d p_term %0d, want %0d", want.out_axis,
                                      out_ch.p_term, want.p_term));
          if (out_ch.i_term !== want.i_term)
            report_mismatch($sformatf("axis %0d i_term %0d, want %0d", want.out_axis,
                                      out_ch.i_term, want.i_term));
          if (out_ch.d_term !== want.d_term)
            report_mismatch($sformatf("axis %0d d_term %0d, want %0d", want.out_axis,
                                      out_ch.d_term, want.d_term));
        end
      end
    end
  end

  // Drive input beats from the pending queue, with random idle bursts
  always @(negedge clk) begin : driver
    axis_sample_t nxt;
    logic         drive_valid;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      drive_valid  = in_ch.valid && !sample_taken;
      sample_taken = 1'b0;
      if (!drive_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_samples.size() != 0) begin
          if (send_idle_on && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(0, 17);
          end else begin
            nxt = pending_samples.pop_front();
            in_ch.axis                 <= nxt.axis;
            in_ch.setpoint_rate        <= nxt.setpoint_rate;
            in_ch.gyro_rate            <= nxt.gyro_rate;
            in_ch.throttle_attenuation <= nxt.throttle_attenuation;
            in_ch.motor_mix_range      <= nxt.motor_mix_range;
            in_ch.stick_deflection     <= nxt.stick_deflection;
            in_ch.iterm_boost          <= nxt.iterm_boost;
            in_ch.stabilise_on         <= nxt.stabilise_on;
            in_ch.clear_integral       <= nxt.clear_integral;
            drive_valid = 1'b1;
          end
        end
      end
      in_ch.valid <= drive_valid;
    end
  end

  // Drive ready: long hold-off first, then random stall bursts
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_ch.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ch.ready <= 1'b0;
    end else if (recv_idle_on && $urandom_range(0, 7) == 0) begin
      recv_gap = $urandom_range(0, 17);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("TIMEOUT: %0d of %0d samples taken, %0d results pending",
             accepted_count, queued_count, expected_terms_q.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    tuning_t directed_tuning;
    tuning_t phase_tuning [N_PHASES];

    in_ch.valid                = 1'b0;
    in_ch.axis                 = AX_ROLL;
    in_ch.setpoint_rate        = '0;
    in_ch.gyro_rate            = '0;
    in_ch.throttle_attenuation = '0;
    in_ch.motor_mix_range      = '0;
    in_ch.stick_deflection     = '0;
    in_ch.iterm_boost          = '0;
    in_ch.stabilise_on         = 1'b0;
    in_ch.clear_integral       = 1'b0;
    out_ch.ready               = 1'b0;
    cfg_we                     = 1'b0;
    cfg_index                  = CFG_KP;
    cfg_data                   = '0;

    active_tuning = '{kp: '0, ki_dt: '0, kd_dt: '0, max_step: '0, weight: WEIGHT_RST,
                      relax: RELAX_RST, windup: WINDUP_RST};
    for (int k = 0; k < N_AXES; k++) begin
      prev_setpoint[k]   = 0;
      integral_sum[k]    = 0;
      last_derivative[k] = 0;
    end
    prev_weighted_err[0] = 0;
    prev_weighted_err[1] = 0;
    for (int k = 0; k < AXIS_SLOTS; k++) walk_sp[k] = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register values straight out of reset
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    offer(make_sample(AX_ROLL, 100 * DEG, 10 * DEG, 32768, 0, 16384, 256, 1'b1, 1'b0));
    offer(make_sample(AX_PITCH, -50 * DEG, 5 * DEG, 20000, 4000, 32768, 256, 1'b1, 1'b0));
    offer(make_sample(AX_YAW, 30 * DEG, -30 * DEG, 32768, 0, 0, 256, 1'b1, 1'b0));
    settle();

    // Directed corners under a hand-picked tuning
    directed_tuning = '{kp: 48'h0100_0200_0180, ki_dt: 48'h0800_1000_2000,
                        kd_dt: 48'h0000_0040_0080, max_step: 48'h0050_0000_0100,
                        weight: 16'hC000, relax: 16'h0400, windup: 16'h0300};
    apply_settings(directed_tuning);
    // slew clamp on roll, twice in a row
    offer(make_sample(AX_ROLL, 100 * DEG, 0, 32768, 0, 32768, 256, 1'b1, 1'b0));
    offer(make_sample(AX_ROLL, 100 * DEG, 0, 32768, 0, 32768, 256, 1'b1, 1'b0));
    // error saturation with the pitch limit disabled
    offer(make_sample(AX_PITCH, Q_MAX, Q_MIN, 32768, 0, 32768, 256, 1'b1, 1'b0));
    offer(make_sample(AX_PITCH, Q_MIN, Q_MAX, 32768, 0, 32768, 256, 1'b1, 1'b0));
    offer(make_sample(AX_YAW, 50 * DEG, -20 * DEG, 32768, 16383, 0, 256, 1'b1, 1'b0));
    // saturated mix holds the integral
    offer(make_sample(AX_ROLL, 20 * DEG, 0, 32768, 16384, 8000, 256, 1'b1, 1'b0));
    offer(make_sample(AX_ROLL, 25 * DEG, 3 * DEG, 32768, 65535, 8000, 256, 1'b1, 1'b0));
    offer(make_sample(AX_PITCH, 40 * DEG, 2 * DEG, 0, 1000, 32768, 256, 1'b1, 1'b0));
    offer(make_sample(AX_PITCH, 40 * DEG, -2 * DEG, 32768, 0, 32768, 65535, 1'b1, 1'b0));
    offer(make_sample(AX_ROLL, 10 * DEG, 1 * DEG, 32768, 0, 32768, 0, 1'b1, 1'b0));
    // stick relax: no deflection, then half
    offer(make_sample(AX_ROLL, 12 * DEG, 1 * DEG, 32768, 0, 0, 256, 1'b1, 1'b0));
    offer(make_sample(AX_PITCH, 12 * DEG, 1 * DEG, 32768, 0, 16384, 256, 1'b1, 1'b0));
    // disabled, cleared integral, invalid axis
    offer(make_sample(AX_ROLL, 30 * DEG, 5 * DEG, 32768, 0, 32768, 256, 1'b0, 1'b0));
    offer(make_sample(AX_PITCH, 30 * DEG, 5 * DEG, 32768, 0, 32768, 256, 1'b1, 1'b1));
    offer(make_sample(AX_BAD, 30 * DEG, 5 * DEG, 32768, 0, 32768, 256, 1'b1, 1'b1));
    offer(make_sample(AX_BAD, Q_MIN, Q_MAX, 32768, 65535, 32768, 65535, 1'b1, 1'b0));
    offer(make_sample(AX_YAW, 60 * DEG, 5 * DEG, 32768, 0, 32768, 256, 1'b0, 1'b0));
    offer(make_sample(AX_YAW, Q_MIN, 0, 32768, 0, 32768, 256, 1'b1, 1'b0));
    offer(make_sample(AX_ROLL, Q_MAX, Q_MAX, 32768, 0, 32768, 65535, 1'b1, 1'b0));
    offer(make_sample(AX_PITCH, 0, 0, 32768, 8192, 32768, 256, 1'b1, 1'b0));
    settle();

    // Random phases, each under its own tuning, extremes included
    phase_tuning[0] = directed_tuning;
    phase_tuning[1] = '{kp: '0, ki_dt: '0, kd_dt: '0, max_step: '0, weight: '0,
                        relax: '0, windup: '0};
    phase_tuning[2] = random_tuning();
    phase_tuning[3] = '{kp: '1, ki_dt: '1, kd_dt: '1, max_step: '1, weight: '1,
                        relax: '1, windup: '1};
    phase_tuning[4] = random_tuning();
    phase_tuning[5] = random_tuning();
    phase_tuning[6] = random_tuning();
    phase_tuning[7] = directed_tuning;
    phase_tuning[5].relax = RELAX_ONE;
    phase_tuning[6].relax = RELAX_ONE + 16'd1;

    for (int ph = 0; ph < N_PHASES; ph++) begin
      apply_settings(phase_tuning[ph]);
      send_idle_on = (ph != N_PHASES - 1) && (ph % 3 != 1);
      recv_idle_on = (ph != N_PHASES - 1) && (ph % 3 != 2);
      for (int n = 0; n < PHASE_SAMPLES; n++) offer(random_sample($urandom_range(0, 99) < 15));
      // stall the result side long enough to back up the input
      if (ph == 2) hold_off_left = HOLD_CYCLES;
      settle();
    end

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
